>>> rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants, types and helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

   localparam int MaxWidth      = 1024;
   localparam int ChannelBits   = 8;
   localparam int ColBits       = $clog2(MaxWidth);
   localparam int RowBits       = 16;
   localparam int CfgWidthBits  = 11;
   localparam int CfgHeightBits = 16;
   localparam int PixBits       = 3 * ChannelBits;
   localparam int ColSumBits    = ChannelBits + 2;
   localparam int SumBits       = ChannelBits + 4;
   localparam int RecipShift    = SumBits + 4;
   localparam int Recip9        = (2 ** RecipShift) / 9 + 1;
   localparam int QueueDepth    = 4;
   localparam int QPtrBits      = $clog2(QueueDepth);
   localparam int QCntBits      = QPtrBits + 1;
   localparam int CsrIndexBits  = 4;
   localparam int CsrDataBits   = 16;

   localparam int FrameWidthReset  = 640;
   localparam int FrameHeightReset = 480;

   localparam logic [CsrIndexBits-1:0] RegFrameWidth  = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] RegFrameHeight = CsrIndexBits'(1);

   typedef struct packed {
      logic [ChannelBits-1:0] red;
      logic [ChannelBits-1:0] green;
      logic [ChannelBits-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [SumBits-1:0] red;
      logic [SumBits-1:0] green;
      logic [SumBits-1:0] blue;
   } sum_type;

   typedef struct packed {
      logic [ColBits-1:0] pos_x;
      logic [RowBits-1:0] pos_y;
      pixel_type          pix;
      sum_type            sum;
      logic               do_centre;
      logic               do_border;
   } job_type;

   function automatic logic [ChannelBits-1:0] div9(input logic [SumBits-1:0] s);
      logic [SumBits+RecipShift-1:0] p;
      p = (SumBits + RecipShift)'(s) * (SumBits + RecipShift)'(Recip9);
      return p[RecipShift +: ChannelBits];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/bb3_intf.sv
// ----------------------------------------------------------------------------
// bb3 channel interfaces
// Pixel request, result and register write channels of the box blur.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3_req_if;
   logic                               valid;
   logic                               ready;
   logic [bb3_pkg::ChannelBits-1:0]    in_red;
   logic [bb3_pkg::ChannelBits-1:0]    in_green;
   logic [bb3_pkg::ChannelBits-1:0]    in_blue;
   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bb3_pkg::ColBits-1:0]        pos_x;
   logic [bb3_pkg::RowBits-1:0]        pos_y;
   logic [bb3_pkg::ChannelBits-1:0]    out_red;
   logic [bb3_pkg::ChannelBits-1:0]    out_green;
   logic [bb3_pkg::ChannelBits-1:0]    out_blue;
   logic                               is_blurred;
   logic                               last_of_run;
   modport source (output valid, pos_x, pos_y, out_red, out_green, out_blue,
                   is_blurred, last_of_run, input ready);
   modport sink   (input valid, pos_x, pos_y, out_red, out_green, out_blue,
                   is_blurred, last_of_run, output ready);
endinterface

interface bb3_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bb3_pkg::CsrIndexBits-1:0]   index;
   logic [bb3_pkg::CsrDataBits-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rgb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// Streaming 3x3 box blur on raster-order RGB pixels with border pass-through.
//
//   channel   dir   payload
//   req_if    in    in_red, in_green, in_blue
//   rsp_if    out   pos_x, pos_y, out_red/green/blue, is_blurred, last_of_run
//   csr_if    in    index (0 frame_width, 1 frame_height), data
//
// one pixel accepted per cycle while the job queue has room
// a pixel that yields two results (right column, bottom row) holds the
// single result port for both; a four-entry job queue absorbs this
// at the right column, along the bottom row input slows to the output rate
// line stores are two 1024 x 24 RAMs, written in the cycle after the read
// synchronous reset, no clearing pass; a frame size write restarts the frame
// rsp_ready low stalls the output register, then the queue, then req_ready
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_box_blur_3x3 (
   input  wire logic   clock,
   input  wire logic   reset,
   bb3_req_if.sink     req_if,
   bb3_rsp_if.source   rsp_if,
   bb3_csr_if.sink     csr_if
);

   logic                            push, pop, head_valid;
   bb3_pkg::job_type                push_job, head;
   logic [bb3_pkg::QCntBits-1:0]    q_count;

   bb3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .csr      (csr_if),
      .q_count  (q_count),
      .push     (push),
      .push_job (push_job)
   );

   bb3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .count      (q_count)
   );

   bb3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule

`default_nettype wire

>>> rtl/core/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(Depth)-1:0]   wr_addr,
   input  wire logic [Width-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(Depth)-1:0]   rd_addr,
   output logic      [Width-1:0]           rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Accepts pixels, tracks position, keeps line stores and column-sum window,
// classifies each pixel and pushes a job for each pixel that yields a result.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bb3_req_if.sink                            req,
   bb3_csr_if.sink                            csr,
   input  wire logic [bb3_pkg::QCntBits-1:0]  q_count,
   output logic                               push,
   output bb3_pkg::job_type                   push_job
);

   localparam int XW  = bb3_pkg::CfgWidthBits;
   localparam int YW  = bb3_pkg::RowBits + 1;
   localparam int CB  = bb3_pkg::ColBits;
   localparam int RB  = bb3_pkg::RowBits;
   localparam int CSB = bb3_pkg::ColSumBits;
   localparam int SB  = bb3_pkg::SumBits;
   localparam int HB  = bb3_pkg::CfgHeightBits;

   typedef struct packed {
      logic [CSB-1:0] red;
      logic [CSB-1:0] green;
      logic [CSB-1:0] blue;
   } colsum_type;

   logic [XW-1:0]        width_ff, width_in;
   logic [HB-1:0]        height_ff, height_in;
   logic [CB-1:0]        x_ff, x_in;
   logic [RB-1:0]        y_ff, y_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [CB-1:0]        s1_x_ff;
   logic [RB-1:0]        s1_y_ff;
   bb3_pkg::pixel_type   s1_pix_ff;
   logic                 s1_centre_ff, s1_border_ff;
   colsum_type           win_a_ff, win_a_in, win_b_ff, win_b_in;

   logic [XW-1:0]        eff_w, x_inc;
   logic [HB-1:0]        eff_h;
   logic [YW-1:0]        y_inc;
   logic                 accept, csr_hit, x_last, y_last, small_frame;
   logic                 centre, border;
   bb3_pkg::pixel_type   cur_pix, top_pix, mid_pix;
   colsum_type           col;
   bb3_pkg::sum_type     sum;
   logic [bb3_pkg::PixBits-1:0] top_raw, mid_raw;

   function automatic logic [CSB-1:0] add3(input logic [bb3_pkg::ChannelBits-1:0] a,
                                           input logic [bb3_pkg::ChannelBits-1:0] b,
                                           input logic [bb3_pkg::ChannelBits-1:0] c);
      return CSB'(a) + CSB'(b) + CSB'(c);
   endfunction

   assign csr.ready = 1'b1;
   assign csr_hit   = csr.valid && (csr.index == bb3_pkg::RegFrameWidth ||
                                    csr.index == bb3_pkg::RegFrameHeight);
   assign req.ready = (int'(q_count) + int'(s1_valid_ff)) < bb3_pkg::QueueDepth;
   assign accept    = req.valid && req.ready;
   assign cur_pix   = '{red: req.in_red, green: req.in_green, blue: req.in_blue};

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         eff_w = XW'(1);
      end else if (width_ff > XW'(bb3_pkg::MaxWidth)) begin
         eff_w = XW'(bb3_pkg::MaxWidth);
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff == '0) ? HB'(1) : height_ff;
   end

   assign x_inc       = XW'(x_ff) + XW'(1);
   assign y_inc       = YW'(y_ff) + YW'(1);
   assign x_last      = x_inc >= eff_w;
   assign y_last      = y_inc >= YW'(eff_h);
   assign small_frame = eff_w < XW'(3) || eff_h < HB'(3);
   assign centre      = !small_frame && x_ff >= CB'(2) && y_ff >= RB'(2);
   assign border      = small_frame || x_ff == '0 || y_ff == '0 || x_last || y_last;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      if (csr.valid && csr.index == bb3_pkg::RegFrameWidth) begin
         width_in = csr.data[XW-1:0];
      end
      if (csr.valid && csr.index == bb3_pkg::RegFrameHeight) begin
         height_in = csr.data[HB-1:0];
      end
      if (csr_hit) begin
         x_in = '0;
         y_in = '0;
      end else if (accept) begin
         if (x_last) begin
            x_in = '0;
            y_in = y_last ? '0 : y_inc[RB-1:0];
         end else begin
            x_in = x_inc[CB-1:0];
         end
      end
   end

   // line stores
   bb3_ram #(.Width(bb3_pkg::PixBits), .Depth(bb3_pkg::MaxWidth)) u_row_older (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (mid_raw),
      .rd_en   (accept),
      .rd_addr (x_ff),
      .rd_data (top_raw)
   );

   bb3_ram #(.Width(bb3_pkg::PixBits), .Depth(bb3_pkg::MaxWidth)) u_row_newer (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (x_ff),
      .rd_data (mid_raw)
   );

   assign top_pix = top_raw;
   assign mid_pix = mid_raw;

   always_comb begin
      col.red   = add3(top_pix.red,   mid_pix.red,   s1_pix_ff.red);
      col.green = add3(top_pix.green, mid_pix.green, s1_pix_ff.green);
      col.blue  = add3(top_pix.blue,  mid_pix.blue,  s1_pix_ff.blue);
      sum.red   = SB'(win_a_ff.red)   + SB'(win_b_ff.red)   + SB'(col.red);
      sum.green = SB'(win_a_ff.green) + SB'(win_b_ff.green) + SB'(col.green);
      sum.blue  = SB'(win_a_ff.blue)  + SB'(win_b_ff.blue)  + SB'(col.blue);
      win_a_in  = s1_valid_ff ? win_b_ff : win_a_ff;
      win_b_in  = s1_valid_ff ? col : win_b_ff;
   end

   assign s1_valid_in = accept;

   assign push               = s1_valid_ff && (s1_centre_ff || s1_border_ff);
   assign push_job.pos_x     = s1_x_ff;
   assign push_job.pos_y     = s1_y_ff;
   assign push_job.pix       = s1_pix_ff;
   assign push_job.sum       = sum;
   assign push_job.do_centre = s1_centre_ff;
   assign push_job.do_border = s1_border_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= XW'(bb3_pkg::FrameWidthReset);
         height_ff   <= HB'(bb3_pkg::FrameHeightReset);
         x_ff        <= '0;
         y_ff        <= '0;
         s1_valid_ff <= 1'b0;
         win_a_ff    <= '0;
         win_b_ff    <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         s1_valid_ff <= s1_valid_in;
         win_a_ff    <= win_a_in;
         win_b_ff    <= win_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff      <= x_ff;
         s1_y_ff      <= y_ff;
         s1_pix_ff    <= cur_pix;
         s1_centre_ff <= centre;
         s1_border_ff <= border;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bb3_queue.sv
// ----------------------------------------------------------------------------
// bb3_queue
// Short job queue between the pixel front end and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire bb3_pkg::job_type              push_job,
   input  wire logic                          pop,
   output bb3_pkg::job_type                   head,
   output logic                               head_valid,
   output logic [bb3_pkg::QCntBits-1:0]       count
);

   localparam int PB = bb3_pkg::QPtrBits;
   localparam int NB = bb3_pkg::QCntBits;

   bb3_pkg::job_type   slot_ff [bb3_pkg::QueueDepth];
   logic [PB-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0]      count_ff, count_in;
   logic               do_pop;

   assign do_pop     = pop && count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff + NB'(push) - NB'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Result stage: divides window sums by nine and emits up to two results
// per job, blurred centre first, through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bb3_pkg::job_type     head,
   input  wire logic                 head_valid,
   output logic                      pop,
   bb3_rsp_if.source                 rsp
);

   localparam int CB = bb3_pkg::ColBits;
   localparam int RB = bb3_pkg::RowBits;

   logic                 valid_ff, valid_in;
   logic                 phase_ff, phase_in;
   logic [CB-1:0]        pos_x_ff;
   logic [RB-1:0]        pos_y_ff;
   bb3_pkg::pixel_type   pix_ff, pix_in, avg;
   logic                 blurred_ff, last_ff, last_in;
   logic                 load, emit_centre;

   assign load        = head_valid && (!valid_ff || rsp.ready);
   assign emit_centre = head.do_centre && !phase_ff;
   assign last_in     = !(emit_centre && head.do_border);
   assign pop         = load && last_in;

   assign avg.red   = bb3_pkg::div9(head.sum.red);
   assign avg.green = bb3_pkg::div9(head.sum.green);
   assign avg.blue  = bb3_pkg::div9(head.sum.blue);
   assign pix_in    = emit_centre ? avg : head.pix;

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff;
      if (load) begin
         phase_in = !last_in;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_x_ff   <= emit_centre ? head.pos_x - CB'(1) : head.pos_x;
         pos_y_ff   <= emit_centre ? head.pos_y - RB'(1) : head.pos_y;
         pix_ff     <= pix_in;
         blurred_ff <= emit_centre;
         last_ff    <= last_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.pos_x       = pos_x_ff;
   assign rsp.pos_y       = pos_y_ff;
   assign rsp.out_red     = pix_ff.red;
   assign rsp.out_green   = pix_ff.green;
   assign rsp.out_blue    = pix_ff.blue;
   assign rsp.is_blurred  = blurred_ff;
   assign rsp.last_of_run = last_ff;

endmodule

`default_nettype wire

>>> rtl/core/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [bb3_pkg::ColBits-1:0]       rsp_pos_x,
   input  wire logic [bb3_pkg::RowBits-1:0]       rsp_pos_y,
   input  wire logic                              rsp_is_blurred,
   input  wire logic                              rsp_last_of_run
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_blur_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_blurred |-> rsp_pos_x != '0 && rsp_pos_y != '0)
      else $error("blurred result on first row or column");

   a_border_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_blurred |-> rsp_last_of_run)
      else $error("border result not last of its run");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y))
      else $error("stalled result changed");

endmodule

bind rgb_box_blur_3x3 bb3_checker u_bb3_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_pos_x       (rsp_if.pos_x),
   .rsp_pos_y       (rsp_if.pos_y),
   .rsp_is_blurred  (rsp_if.is_blurred),
   .rsp_last_of_run (rsp_if.last_of_run)
);

`default_nettype wire
